FILE: sv/wbmm_pkg.sv
package wbmm_pkg;

    // fixed register and field widths
    localparam int BCOUNT_W   = 13;
    localparam int TFRAMES_W  = 40;
    localparam int CFG_DW     = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int BUCKET_W   = 12;
    // quotient bits: the bucket is always below bucket_count, so it fits its width
    localparam int QUO_W      = BCOUNT_W;

    // register values after reset
    localparam logic [BCOUNT_W-1:0]  BCOUNT_RST  = 13'd1024;
    localparam logic [TFRAMES_W-1:0] TFRAMES_RST = 40'd1;

    // item operation codes
    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_READ    = 2'd1,
        OP_RESTART = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BUCKET_COUNT = 2'd0,
        REG_TOTAL_FRAMES = 2'd1,
        REG_STEREO_MODE  = 2'd2
    } reg_idx_t;

endpackage

FILE: sv/wbmm_div.sv
module wbmm_div #(
    parameter int POSITION_BITS = 40
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            start,
    input  logic [POSITION_BITS+wbmm_pkg::QUO_W-1:0]        dividend,
    input  logic [wbmm_pkg::TFRAMES_W-1:0]                  divisor,
    output logic                                            done,
    output logic [wbmm_pkg::QUO_W-1:0]                      quotient
);
    import wbmm_pkg::*;

    localparam int PW = POSITION_BITS + QUO_W;
    localparam int DW = (POSITION_BITS > TFRAMES_W) ? POSITION_BITS : TFRAMES_W;
    localparam int RW = DW + 1;
    localparam int CW = $clog2(QUO_W + 1);

    logic [RW-1:0]    rem_reg;
    logic [QUO_W-1:0] low_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [CW-1:0]    cnt_reg;
    logic             done_reg;

    logic [RW-1:0]    trial;
    logic [RW-1:0]    diff;
    logic             fits;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {rem_reg[RW-2:0], low_reg[QUO_W-1]};
        fits  = trial >= RW'(divisor);
        diff  = trial - RW'(divisor);
    end

    // the upper dividend bits are already below the divisor, so only the
    // low quotient bits remain to be found, one per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= !start && (cnt_reg == CW'(1));
            if (start) begin
                rem_reg <= RW'(dividend[PW-1:QUO_W]);
                low_reg <= dividend[QUO_W-1:0];
                cnt_reg <= CW'(QUO_W);
            end else if (cnt_reg != '0) begin
                rem_reg  <= fits ? diff : trial;
                low_reg  <= {low_reg[QUO_W-2:0], 1'b0};
                quo_reg  <= {quo_reg[QUO_W-2:0], fits};
                cnt_reg  <= cnt_reg - 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: sv/waveform_bucket_min_max.sv
// min/max peak decimation of an audio stream into display buckets.
// input channel (s_*): op 0 pushes a frame (s_sample_left, s_sample_right),
//   op 1 reads bucket s_read_index, op 2 restarts (position and fill flags
//   cleared), op 3 does nothing. every item gives exactly one result.
// result channel (m_*): bucket, dropped flag, fill flags and the extremes of
//   both channels; extremes of an unfilled channel read as zero.
// configuration: write cfg_data to register cfg_index when cfg_we is high
//   (0 bucket_count, 1 total_frames, 2 stereo_mode), only while idle.
// one item is worked on at a time. a push is handled in steps: the product of
//   position and bucket count is registered, the divider is loaded, then come
//   13 restoring divide steps, one memory read, then the update, written back
//   as the result is loaded. a read, a dropped push or op 3 goes from its
//   transfer straight to a result state, which loads the result once the output
//   register is free. the block is back in idle, with s_ready high, as a result is loaded.
// a restart sweeps the fill flags of every bucket in both memories, then gives
//   its result. after reset the same sweep runs with s_ready low; configuration
//   writes are taken throughout.
// the result sits in an output register: while the receiver stalls it is
//   held, the next transfer is still taken and worked on, then s_ready stays low.
module waveform_bucket_min_max #(
    parameter int MAX_BUCKETS   = 4096,
    parameter int SAMPLE_BITS   = 24,
    parameter int POSITION_BITS = 40
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_we,
    input  logic [wbmm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wbmm_pkg::CFG_DW-1:0]         cfg_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  wbmm_pkg::op_t                       s_op,
    input  logic signed [SAMPLE_BITS-1:0]       s_sample_left,
    input  logic signed [SAMPLE_BITS-1:0]       s_sample_right,
    input  logic [wbmm_pkg::BUCKET_W-1:0]       s_read_index,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [wbmm_pkg::BUCKET_W-1:0]       m_bucket,
    output logic                                m_dropped,
    output logic                                m_filled_left,
    output logic                                m_filled_right,
    output logic signed [SAMPLE_BITS-1:0]       m_min_left,
    output logic signed [SAMPLE_BITS-1:0]       m_max_left,
    output logic signed [SAMPLE_BITS-1:0]       m_min_right,
    output logic signed [SAMPLE_BITS-1:0]       m_max_right
);
    import wbmm_pkg::*;

    localparam int IDX_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int PW    = POSITION_BITS + QUO_W;
    localparam int DW    = (POSITION_BITS > TFRAMES_W) ? POSITION_BITS : TFRAMES_W;
    localparam int LIM_W = 18;
    localparam logic [LIM_W-1:0] MAXB_V = LIM_W'(MAX_BUCKETS);
    localparam logic [LIM_W-1:0] LAST_V = LIM_W'(MAX_BUCKETS - 1);
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    typedef struct packed {
        logic                          filled;
        logic signed [SAMPLE_BITS-1:0] lo;
        logic signed [SAMPLE_BITS-1:0] hi;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_UPD,
        ST_RPT,
        ST_RESP
    } state_t;

    state_t                         state_reg;
    logic [BCOUNT_W-1:0]            bcount_reg;
    logic [TFRAMES_W-1:0]           tframes_reg;
    logic                           stereo_reg;
    logic [POSITION_BITS-1:0]       pos_reg;
    logic [IDX_W-1:0]               sweep_reg;
    logic                           clr_resp_reg;

    logic signed [SAMPLE_BITS-1:0]  smp_l_reg;
    logic signed [SAMPLE_BITS-1:0]  smp_r_reg;
    logic [PW-1:0]                  product_reg;
    logic [IDX_W-1:0]               addr_reg;
    logic [BUCKET_W-1:0]            bkt_reg;
    logic                           drop_reg;

    logic                           m_valid_reg;
    logic [BUCKET_W-1:0]            m_bucket_reg;
    logic                           m_dropped_reg;
    entry_t                         m_left_reg;
    entry_t                         m_right_reg;

    // extremes memories, one entry per bucket with its fill flag
    entry_t                         ram_l [MAX_BUCKETS];
    entry_t                         ram_r [MAX_BUCKETS];
    entry_t                         rd_l_reg;
    entry_t                         rd_r_reg;

    logic [BCOUNT_W-1:0]            nb_eff;
    logic                           push_drop;
    logic                           rd_in_range;
    logic                           out_free;
    logic                           res_load;
    logic                           div_start;
    logic                           div_done;
    logic [QUO_W-1:0]               div_quo;
    entry_t                         view_l;
    entry_t                         view_r;
    entry_t                         new_l;
    entry_t                         new_r;
    entry_t                         res_l;
    entry_t                         res_r;
    logic                           mem_re;
    logic [IDX_W-1:0]               mem_raddr;
    logic                           we_l;
    logic                           we_r;
    logic [IDX_W-1:0]               mem_waddr;
    entry_t                         wd_l;
    entry_t                         wd_r;

    // bucket index divider
    wbmm_div #(
        .POSITION_BITS (POSITION_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (product_reg),
        .divisor  (tframes_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // bucket count clamp and drop decision; pos < total implies bucket < count
    always_comb begin
        nb_eff      = (LIM_W'(bcount_reg) > MAXB_V) ? BCOUNT_W'(MAXB_V) : bcount_reg;
        push_drop   = (nb_eff == '0) || !(DW'(pos_reg) < DW'(tframes_reg));
        rd_in_range = LIM_W'(s_read_index) < MAXB_V;
        out_free    = !m_valid_reg || m_ready;
        res_load    = (state_reg inside {ST_UPD, ST_RPT, ST_RESP}) && out_free;
        div_start   = (state_reg == ST_MUL);
    end

    // min/max update of the stored entry, and the entries the result shows
    always_comb begin
        view_l = rd_l_reg.filled ? rd_l_reg : '0;
        view_r = rd_r_reg.filled ? rd_r_reg : '0;

        new_l.filled = 1'b1;
        new_l.lo     = (!rd_l_reg.filled || (smp_l_reg < rd_l_reg.lo)) ? smp_l_reg : rd_l_reg.lo;
        new_l.hi     = (!rd_l_reg.filled || (smp_l_reg > rd_l_reg.hi)) ? smp_l_reg : rd_l_reg.hi;
        new_r.filled = 1'b1;
        new_r.lo     = (!rd_r_reg.filled || (smp_r_reg < rd_r_reg.lo)) ? smp_r_reg : rd_r_reg.lo;
        new_r.hi     = (!rd_r_reg.filled || (smp_r_reg > rd_r_reg.hi)) ? smp_r_reg : rd_r_reg.hi;

        res_l = view_l;
        res_r = view_r;
        if (state_reg == ST_UPD) begin
            res_l = new_l;
            if (stereo_reg) begin
                res_r = new_r;
            end
        end else if (state_reg == ST_RESP) begin
            res_l = '0;
            res_r = '0;
        end
    end

    // memory port control
    always_comb begin
        mem_re    = ((state_reg == ST_IDLE) && s_valid && (s_op == OP_READ) && rd_in_range)
                    || ((state_reg == ST_DIV) && div_done);
        mem_raddr = (state_reg == ST_DIV) ? IDX_W'(div_quo) : IDX_W'(s_read_index);
        we_l      = (state_reg == ST_CLEAR) || ((state_reg == ST_UPD) && out_free);
        we_r      = (state_reg == ST_CLEAR) || ((state_reg == ST_UPD) && out_free && stereo_reg);
        mem_waddr = (state_reg == ST_CLEAR) ? sweep_reg : addr_reg;
        wd_l      = (state_reg == ST_CLEAR) ? '0 : new_l;
        wd_r      = (state_reg == ST_CLEAR) ? '0 : new_r;
    end

    // extremes memories, read data registered
    always_ff @(posedge aclk) begin
        if (we_l) begin
            ram_l[mem_waddr] <= wd_l;
        end
        if (we_r) begin
            ram_r[mem_waddr] <= wd_r;
        end
        if (mem_re) begin
            rd_l_reg <= ram_l[mem_raddr];
            rd_r_reg <= ram_r[mem_raddr];
        end
    end

    // sequencer, configuration registers and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            sweep_reg    <= '0;
            clr_resp_reg <= 1'b0;
            pos_reg      <= '0;
            bcount_reg   <= BCOUNT_RST;
            tframes_reg  <= TFRAMES_RST;
            stereo_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_BUCKET_COUNT: bcount_reg  <= cfg_data[BCOUNT_W-1:0];
                    REG_TOTAL_FRAMES: tframes_reg <= cfg_data[TFRAMES_W-1:0];
                    REG_STEREO_MODE:  stereo_reg  <= cfg_data[0];
                    default: ;
                endcase
            end

            // result register: load a finished result, else empty on transfer
            if (res_load) begin
                m_valid_reg   <= 1'b1;
                m_bucket_reg  <= bkt_reg;
                m_dropped_reg <= drop_reg;
                m_left_reg    <= res_l;
                m_right_reg   <= res_r;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                // clearing pass over every fill flag
                ST_CLEAR: begin
                    if (LIM_W'(sweep_reg) == LAST_V) begin
                        sweep_reg    <= '0;
                        clr_resp_reg <= 1'b0;
                        state_reg    <= clr_resp_reg ? ST_RESP : ST_IDLE;
                    end else begin
                        sweep_reg <= sweep_reg + 1'b1;
                    end
                end

                ST_IDLE: begin
                    if (s_valid) begin
                        case (s_op)
                            OP_PUSH: begin
                                bkt_reg     <= '0;
                                drop_reg    <= push_drop;
                                smp_l_reg   <= s_sample_left;
                                smp_r_reg   <= s_sample_right;
                                product_reg <= PW'(pos_reg) * PW'(nb_eff);
                                if (pos_reg != POS_MAX) begin
                                    pos_reg <= pos_reg + 1'b1;
                                end
                                if (push_drop) begin
                                    state_reg <= ST_RESP;
                                end else begin
                                    state_reg <= ST_MUL;
                                end
                            end
                            OP_READ: begin
                                bkt_reg   <= s_read_index;
                                drop_reg  <= 1'b0;
                                state_reg <= rd_in_range ? ST_RPT : ST_RESP;
                            end
                            OP_RESTART: begin
                                bkt_reg      <= '0;
                                drop_reg     <= 1'b0;
                                pos_reg      <= '0;
                                sweep_reg    <= '0;
                                clr_resp_reg <= 1'b1;
                                state_reg    <= ST_CLEAR;
                            end
                            default: begin
                                bkt_reg   <= '0;
                                drop_reg  <= 1'b0;
                                state_reg <= ST_RESP;
                            end
                        endcase
                    end
                end

                // product is registered, divider starts now
                ST_MUL: begin
                    state_reg <= ST_DIV;
                end

                ST_DIV: begin
                    if (div_done) begin
                        addr_reg  <= IDX_W'(div_quo);
                        bkt_reg   <= BUCKET_W'(div_quo);
                        state_reg <= ST_UPD;
                    end
                end

                // hand the result over once the output register is free
                ST_UPD, ST_RPT, ST_RESP: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_bucket       = m_bucket_reg;
    assign m_dropped      = m_dropped_reg;
    assign m_filled_left  = m_left_reg.filled;
    assign m_filled_right = m_right_reg.filled;
    assign m_min_left     = m_left_reg.lo;
    assign m_max_left     = m_left_reg.hi;
    assign m_min_right    = m_right_reg.lo;
    assign m_max_right    = m_right_reg.hi;

endmodule

FILE: sv/wbmm_checker.sv
module wbmm_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [wbmm_pkg::BUCKET_W-1:0]    m_bucket,
    input logic                             m_dropped,
    input logic                             m_filled_left,
    input logic                             m_filled_right,
    input logic signed [SAMPLE_BITS-1:0]    m_min_left,
    input logic signed [SAMPLE_BITS-1:0]    m_max_left,
    input logic signed [SAMPLE_BITS-1:0]    m_min_right,
    input logic signed [SAMPLE_BITS-1:0]    m_max_right
);
    import wbmm_pkg::*;

    // no result straight after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds its bucket, dropped flag and left extremes
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_bucket) && $stable(m_dropped)
            && $stable(m_min_left) && $stable(m_max_left))
        else $error("stalled result changed");

    // a dropped frame reports nothing else
    a_drop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dropped |-> (m_bucket == '0) && !m_filled_left && !m_filled_right)
        else $error("dropped frame carries bucket data");

    // unfilled channels read as zero
    a_unfilled_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_filled_left || ((m_min_left == '0) && (m_max_left == '0)))
            && (m_filled_right || ((m_min_right == '0) && (m_max_right == '0))))
        else $error("unfilled channel with non-zero extremes");

    // a filled bucket never has its minimum above its maximum
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_filled_left || (m_min_left <= m_max_left))
            && (!m_filled_right || (m_min_right <= m_max_right)))
        else $error("bucket minimum above maximum");

endmodule

bind waveform_bucket_min_max wbmm_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_wbmm_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_bucket       (m_bucket),
    .m_dropped      (m_dropped),
    .m_filled_left  (m_filled_left),
    .m_filled_right (m_filled_right),
    .m_min_left     (m_min_left),
    .m_max_left     (m_max_left),
    .m_min_right    (m_min_right),
    .m_max_right    (m_max_right)
);

FILE: bench/wbmm_checker.sv
`timescale 1ns / 100ps

module wbmm_scoreboard #(
    parameter int MAX_BUCKETS   = 4096,
    parameter int SAMPLE_BITS   = 24,
    parameter int POSITION_BITS = 40
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_we,
    input  logic [wbmm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wbmm_pkg::CFG_DW-1:0]       cfg_data,

    input  logic                              s_valid,
    input  logic                              s_ready,
    input  wbmm_pkg::op_t                     s_op,
    input  logic signed [SAMPLE_BITS-1:0]     s_sample_left,
    input  logic signed [SAMPLE_BITS-1:0]     s_sample_right,
    input  logic [wbmm_pkg::BUCKET_W-1:0]     s_read_index,

    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [wbmm_pkg::BUCKET_W-1:0]     m_bucket,
    input  logic                              m_dropped,
    input  logic                              m_filled_left,
    input  logic                              m_filled_right,
    input  logic signed [SAMPLE_BITS-1:0]     m_min_left,
    input  logic signed [SAMPLE_BITS-1:0]     m_max_left,
    input  logic signed [SAMPLE_BITS-1:0]     m_min_right,
    input  logic signed [SAMPLE_BITS-1:0]     m_max_right,

    output int                                mismatches,
    output int                                pending
);
    import wbmm_pkg::*;

    // one bucket as the result channel shows it
    typedef struct packed {
        logic [BUCKET_W-1:0]           bucket;
        logic                          dropped;
        logic                          filled_left;
        logic                          filled_right;
        logic signed [SAMPLE_BITS-1:0] min_left;
        logic signed [SAMPLE_BITS-1:0] max_left;
        logic signed [SAMPLE_BITS-1:0] min_right;
        logic signed [SAMPLE_BITS-1:0] max_right;
    } bucket_report_t;

    // mirrored registers and bucket state
    logic [BCOUNT_W-1:0]           bucket_count_r;
    logic [TFRAMES_W-1:0]          total_frames_r;
    logic                          stereo_r;
    logic [POSITION_BITS-1:0]      frame_pos;
    logic signed [SAMPLE_BITS-1:0] ext_lo [2][MAX_BUCKETS];
    logic signed [SAMPLE_BITS-1:0] ext_hi [2][MAX_BUCKETS];
    bit                            ext_filled [2][MAX_BUCKETS];
    bucket_report_t                pending_reports [$];

    initial mismatches = 0;

    // fill flags of both channels cleared
    task automatic clear_fill();
        for (int i = 0; i < MAX_BUCKETS; i++) begin
            ext_filled[0][i] = 1'b0;
            ext_filled[1][i] = 1'b0;
        end
    endtask

    // flags and extremes of one bucket, zero where a channel is unfilled
    function automatic bucket_report_t bucket_state(input logic [BUCKET_W-1:0] idx);
        bucket_report_t rep;
        rep = '0;
        rep.bucket = idx;
        if (idx < MAX_BUCKETS) begin
            if (ext_filled[0][idx]) begin
                rep.filled_left = 1'b1;
                rep.min_left    = ext_lo[0][idx];
                rep.max_left    = ext_hi[0][idx];
            end
            if (ext_filled[1][idx]) begin
                rep.filled_right = 1'b1;
                rep.min_right    = ext_lo[1][idx];
                rep.max_right    = ext_hi[1][idx];
            end
        end
        return rep;
    endfunction

    // first sample sets both extremes, later ones only widen them
    task automatic widen_extremes(input int ch, input int unsigned b,
                                  input logic signed [SAMPLE_BITS-1:0] s);
        if (!ext_filled[ch][b]) begin
            ext_lo[ch][b]     = s;
            ext_hi[ch][b]     = s;
            ext_filled[ch][b] = 1'b1;
        end else begin
            if (s < ext_lo[ch][b]) ext_lo[ch][b] = s;
            if (s > ext_hi[ch][b]) ext_hi[ch][b] = s;
        end
    endtask

    // bucket lookup of a pushed frame, update of its extremes and position advance
    task automatic predict_push(input logic signed [SAMPLE_BITS-1:0] left,
                                input logic signed [SAMPLE_BITS-1:0] right,
                                output bucket_report_t rep);
        logic [63:0] nb;
        logic [63:0] pos;
        logic [63:0] tf;
        logic [63:0] quo;
        nb  = 64'(bucket_count_r);
        pos = 64'(frame_pos);
        tf  = 64'(total_frames_r);
        if (nb > 64'(MAX_BUCKETS)) nb = 64'(MAX_BUCKETS);
        if (tf == 0) quo = '1;
        else quo = (pos * nb) / tf;
        if (frame_pos != '1) frame_pos = frame_pos + 1'b1;
        if (quo >= nb) begin
            rep = '0;
            rep.dropped = 1'b1;
        end else begin
            widen_extremes(0, 32'(quo), left);
            if (stereo_r) widen_extremes(1, 32'(quo), right);
            rep = bucket_state(quo[BUCKET_W-1:0]);
        end
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // compare result transfers, then predict input transfers, then mirror writes
    always @(posedge aclk) begin : watch
        bucket_report_t want;
        bucket_report_t got;
        if (!aresetn) begin
            bucket_count_r = BCOUNT_RST;
            total_frames_r = TFRAMES_RST;
            stereo_r       = 1'b0;
            frame_pos      = '0;
            pending_reports.delete();
            clear_fill();
        end else begin
            if (m_valid && m_ready) begin
                got = {m_bucket, m_dropped, m_filled_left, m_filled_right,
                       m_min_left, m_max_left, m_min_right, m_max_right};
                if (pending_reports.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, bucket %0d",
                             $time, m_bucket);
                    mismatches++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("bucket", 32'(want.bucket), 32'(got.bucket));
                    check_field("dropped", 32'(want.dropped), 32'(got.dropped));
                    check_field("filled_left", 32'(want.filled_left),
                                32'(got.filled_left));
                    check_field("filled_right", 32'(want.filled_right),
                                32'(got.filled_right));
                    check_field("min_left", 32'(want.min_left), 32'(got.min_left));
                    check_field("max_left", 32'(want.max_left), 32'(got.max_left));
                    check_field("min_right", 32'(want.min_right), 32'(got.min_right));
                    check_field("max_right", 32'(want.max_right), 32'(got.max_right));
                end
            end
            if (s_valid && s_ready) begin
                case (s_op)
                    OP_PUSH: predict_push(s_sample_left, s_sample_right, want);
                    OP_READ: want = bucket_state(s_read_index);
                    OP_RESTART: begin
                        frame_pos = '0;
                        clear_fill();
                        want = '0;
                    end
                    default: want = '0;
                endcase
                pending_reports.push_back(want);
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_BUCKET_COUNT: bucket_count_r = cfg_data[BCOUNT_W-1:0];
                    REG_TOTAL_FRAMES: total_frames_r = cfg_data[TFRAMES_W-1:0];
                    REG_STEREO_MODE:  stereo_r = cfg_data[0];
                    default: ;
                endcase
            end
        end
        pending <= pending_reports.size();
    end

endmodule

FILE: bench/waveform_bucket_min_max_tb.sv
`timescale 1ns / 100ps

module waveform_bucket_min_max_tb;
    import wbmm_pkg::*;

    localparam int MAX_BUCKETS     = 4096;
    localparam int SAMPLE_BITS     = 24;
    localparam int POSITION_BITS   = 40;
    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 190;
    localparam int LONG_HOLD       = 300;
    localparam int STALL_LIMIT     = 40000;

    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [CFG_DW-1:0]             cfg_data = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    op_t                           s_op = OP_NOP;
    logic signed [SAMPLE_BITS-1:0] s_sample_left = '0;
    logic signed [SAMPLE_BITS-1:0] s_sample_right = '0;
    logic [BUCKET_W-1:0]           s_read_index = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [BUCKET_W-1:0]           m_bucket;
    logic                          m_dropped;
    logic                          m_filled_left;
    logic                          m_filled_right;
    logic signed [SAMPLE_BITS-1:0] m_min_left;
    logic signed [SAMPLE_BITS-1:0] m_max_left;
    logic signed [SAMPLE_BITS-1:0] m_min_right;
    logic signed [SAMPLE_BITS-1:0] m_max_right;

    int mismatches;
    int pending;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int hold_left = 0;
    int idle_cycles = 0;
    int n_push = 0;
    int n_read = 0;
    int n_restart = 0;
    int n_nop = 0;
    int n_settings = 0;
    logic [BCOUNT_W-1:0] cur_bucket_count = BCOUNT_RST;

    waveform_bucket_min_max #(
        .MAX_BUCKETS(MAX_BUCKETS),
        .SAMPLE_BITS(SAMPLE_BITS),
        .POSITION_BITS(POSITION_BITS)
    ) dut (.*);

    wbmm_scoreboard #(
        .MAX_BUCKETS(MAX_BUCKETS),
        .SAMPLE_BITS(SAMPLE_BITS),
        .POSITION_BITS(POSITION_BITS)
    ) u_scoreboard (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // cycles since the last transfer on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge aclk);
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, pending);
        $display("waveform_bucket_min_max: mismatch");
        $finish;
    end

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        logic [31:0] bits;
        bits = $urandom;
        case ($urandom_range(0, 15))
            0: return SMAX;
            1: return SMIN;
            2: return '0;
            default: return bits[SAMPLE_BITS-1:0];
        endcase
    endfunction

    // idling mix: sender light / receiver heavy, then swapped, then none
    task automatic set_idle(input int mode);
        case (mode)
            0: begin tx_idle_pct = 19; rx_idle_pct <= 86; end
            1: begin tx_idle_pct = 86; rx_idle_pct <= 19; end
            default: begin tx_idle_pct = 0; rx_idle_pct <= 0; end
        endcase
    endtask

    // all three registers written back to back, block idle or in its reset sweep
    task automatic set_config(input logic [CFG_DW-1:0] bc, input logic [CFG_DW-1:0] tf,
                              input logic st);
        cfg_we    <= 1'b1;
        cfg_index <= REG_BUCKET_COUNT;
        cfg_data  <= bc;
        @(posedge aclk);
        cfg_index <= REG_TOTAL_FRAMES;
        cfg_data  <= tf;
        @(posedge aclk);
        cfg_index <= REG_STEREO_MODE;
        cfg_data  <= CFG_DW'(st);
        @(posedge aclk);
        cfg_we <= 1'b0;
        cur_bucket_count = bc[BCOUNT_W-1:0];
        n_settings++;
    endtask

    // sender stops until every expected result has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // one input transfer; valid stays high afterwards unless the next gap lowers it
    task automatic send_item(input op_t op, input logic signed [SAMPLE_BITS-1:0] left,
                             input logic signed [SAMPLE_BITS-1:0] right,
                             input logic [BUCKET_W-1:0] idx);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_op           <= op;
        s_sample_left  <= left;
        s_sample_right <= right;
        s_read_index   <= idx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        case (op)
            OP_PUSH:    n_push++;
            OP_READ:    n_read++;
            OP_RESTART: n_restart++;
            default:    n_nop++;
        endcase
    endtask

    initial begin
        logic [CFG_DW-1:0]   bc;
        logic [CFG_DW-1:0]   tf;
        logic                st;
        int                  pick;
        int                  span;
        op_t                 op;
        logic [31:0]         bits;
        logic [BUCKET_W-1:0] idx;

        set_idle(0);
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: eight buckets over 32 frames, stereo
        set_config(8, 32, 1'b1);
        send_item(OP_READ, 0, 0, 0);
        // first frame sets the extremes, later frames widen them
        send_item(OP_PUSH, SMAX, SMIN, 0);
        send_item(OP_PUSH, SMIN, SMAX, 0);
        send_item(OP_PUSH, 0, -1, 0);
        send_item(OP_READ, 0, 0, 0);
        send_item(OP_READ, 0, 0, '1);
        send_item(OP_NOP, SMAX, SMAX, '1);
        // mono: right channel keeps what it stored
        drain();
        set_config(8, 32, 1'b0);
        send_item(OP_PUSH, 1, 5, 0);
        repeat (4) send_item(OP_PUSH, -5, 7, 0);
        send_item(OP_READ, 0, 0, 1);
        // position past the last bucket
        drain();
        set_config(8, 4, 1'b1);
        send_item(OP_PUSH, SMAX, SMAX, 0);
        // zero bucket count drops everything
        drain();
        set_config(0, 4, 1'b1);
        send_item(OP_PUSH, SMAX, SMIN, 0);
        // zero total frames drops everything
        drain();
        set_config(8, 0, 1'b1);
        send_item(OP_PUSH, SMIN, SMAX, 0);
        // restart clears position and fill flags
        send_item(OP_RESTART, 0, 0, 0);
        send_item(OP_READ, 0, 0, 0);
        send_item(OP_PUSH, SMIN, SMIN, 0);

        // random phases, each from a fresh position
        for (int p = 0; p < PHASES; p++) begin
            drain();
            set_idle(p / 3);
            case (p)
                0: begin bc = 16;   tf = 64;              st = 1'b1; end
                1: begin bc = 1;    tf = 1;               st = 1'b0; end
                2: begin bc = 4096; tf = 200;             st = 1'b1; end
                3: begin bc = 8191; tf = 40'hFF_FFFF_FFFF; st = 1'b1; end
                4: begin bc = 0;    tf = 100;             st = 1'b0; end
                5: begin bc = 32;   tf = 0;               st = 1'b1; end
                6: begin bc = 100;  tf = 150;             st = 1'b0; end
                7: begin bc = 5000; tf = 170;             st = 1'b1; end
                default: begin bc = 7; tf = 20;           st = 1'b1; end
            endcase
            set_config(bc, tf, st);
            send_item(OP_RESTART, rand_sample(), rand_sample(), 0);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // receiver holds off while the sender keeps offering
                if (p == 0 && i == 50) hold_req <= 1'b1;
                // sender pauses until the block has drained
                if (p == 1 && i == 40) drain();
                pick = $urandom_range(0, 199);
                if (pick < 140) op = OP_PUSH;
                else if (pick < 190) op = OP_READ;
                else if (pick < 198) op = OP_NOP;
                else op = OP_RESTART;
                span = (cur_bucket_count > MAX_BUCKETS) ? MAX_BUCKETS : cur_bucket_count;
                bits = $urandom;
                if (span != 0 && $urandom_range(0, 3) != 0) bits = $urandom_range(0, span - 1);
                idx = bits[BUCKET_W-1:0];
                send_item(op, rand_sample(), rand_sample(), idx);
            end
        end

        drain();
        repeat (30) @(posedge aclk);
        $display("covered %0d pushes, %0d reads, %0d restarts and %0d no-ops",
                 n_push, n_read, n_restart, n_nop);
        $display("over %0d register settings, three idling mixes, a long result hold-off",
                 n_settings);
        if (mismatches == 0 && pending == 0) begin
            $display("waveform_bucket_min_max: match");
        end else begin
            $display("waveform_bucket_min_max: mismatch");
        end
        $finish;
    end

endmodule
